>>> sv/ftu_pkg.sv
// Shared types and constants for the FSK tone UART receiver.
package ftu_pkg;

  localparam int ValW = 16;
  localparam int SymW = 2;
  localparam int CharW = 8;
  localparam int CountW = 4;
  localparam int CfgIdxW = 8;

  localparam logic [SymW-1:0] SYM_ZERO = 2'd0;
  localparam logic [SymW-1:0] SYM_ONE  = 2'd1;
  localparam logic [SymW-1:0] SYM_NONE = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_ONE_MIN  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_ONE_MAX  = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_ZERO_MIN = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_ZERO_MAX = 8'd3;

  localparam logic [CountW-1:0] FRAME_DATA_BITS = 4'd8;
  localparam logic [CountW-1:0] FRAME_PARITY_POS = 4'd9;
  localparam logic [CountW-1:0] FRAME_STOP_POS = 4'd10;
  localparam logic [1:0] ZERO_LAST_PHASE = 2'd3;

  typedef struct packed {
    logic [ValW-1:0] one_min;
    logic [ValW-1:0] one_max;
    logic [ValW-1:0] zero_min;
    logic [ValW-1:0] zero_max;
  } thresh_t;

  typedef struct packed {
    logic [SymW-1:0]  bit_symbol;
    logic             char_done;
    logic [CharW-1:0] rx_char;
  } result_t;

endpackage

>>> sv/fsk_tone_uart_receiver.sv
// FSK tone UART receiver: classifier front end, symbol queue, framer, result queue.
// Each pushed word is classified into the symbol queue, then framed into the result queue.
// Throughput: one measurement per cycle; full only when the symbol queue backs up.
// The symbol queue (4 words) and result queue (2 words) decouple the two halves.
// Reset (synchronous, rst high) clears both queues, all framer and phase state,
// and sets every tone threshold to 0.
module fsk_tone_uart_receiver #(
  parameter int TICK_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [ftu_pkg::ValW-1:0]    half_period_ticks,
  output logic                        empty,
  input  logic                        pop,
  output logic [ftu_pkg::SymW-1:0]    bit_symbol,
  output logic                        char_done,
  output logic [ftu_pkg::CharW-1:0]   rx_char,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ftu_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ftu_pkg::ValW-1:0]    cfg_data
);
  import ftu_pkg::*;

  localparam int SymDepth = 4;
  localparam int ResDepth = 2;
  localparam int ResW = $bits(result_t);

  thresh_t thresh;
  logic in_take;
  logic [SymW-1:0] front_sym;
  logic [SymW-1:0] q_sym;
  logic q_empty;
  logic res_full;
  logic back_take;
  result_t back_result;
  result_t out_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ONE_MIN:  thresh.one_min <= cfg_data;
        REG_ONE_MAX:  thresh.one_max <= cfg_data;
        REG_ZERO_MIN: thresh.zero_min <= cfg_data;
        REG_ZERO_MAX: thresh.zero_max <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_take = push && !full;

  ftu_front #(.TICK_WIDTH(TICK_WIDTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .take   (in_take),
    .ticks  (half_period_ticks),
    .thresh (thresh),
    .sym    (front_sym)
  );

  ftu_fifo #(.WIDTH(SymW), .DEPTH(SymDepth)) u_sym_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_take),
    .wr_data (front_sym),
    .rd_en   (back_take),
    .rd_data (q_sym),
    .full    (full),
    .empty   (q_empty)
  );

  assign back_take = !q_empty && !res_full;

  ftu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .take   (back_take),
    .sym    (q_sym),
    .result (back_result)
  );

  ftu_fifo #(.WIDTH(ResW), .DEPTH(ResDepth)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (back_take),
    .wr_data (back_result),
    .rd_en   (pop),
    .rd_data (out_word),
    .full    (res_full),
    .empty   (empty)
  );

  assign bit_symbol = out_word.bit_symbol;
  assign char_done = out_word.char_done;
  assign rx_char = out_word.rx_char;

endmodule

>>> sv/ftu_fifo.sv
// Small register FIFO used between the receiver stages.
module ftu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [PtrW-1:0] LastC = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic do_wr;
  logic do_rd;

  assign full = (count == DepthC);
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastC) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastC) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/ftu_front.sv
// Front end: tone window classification and half-period phase tracking.
module ftu_front #(
  parameter int TICK_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic [ftu_pkg::ValW-1:0] ticks,
  input  ftu_pkg::thresh_t         thresh,
  output logic [ftu_pkg::SymW-1:0] sym
);
  import ftu_pkg::*;

  // compare only the bits a tick counter of this width would hold
  localparam int CmpW = (TICK_WIDTH < ValW) ? TICK_WIDTH : ValW;

  logic one_half_phase;
  logic one_half_phase_next;
  logic [1:0] zero_half_phase;
  logic [1:0] zero_half_phase_next;
  logic [CmpW-1:0] t;
  logic one_hit;
  logic zero_hit;

  assign t = ticks[CmpW-1:0];
  assign one_hit = (thresh.one_min[CmpW-1:0] < t) && (t < thresh.one_max[CmpW-1:0]);
  assign zero_hit = (thresh.zero_min[CmpW-1:0] < t) && (t < thresh.zero_max[CmpW-1:0]);

  always_comb begin
    sym = SYM_NONE;
    one_half_phase_next = one_half_phase;
    zero_half_phase_next = zero_half_phase;
    if (one_hit) begin
      zero_half_phase_next = 2'd0;
      if (!one_half_phase) begin
        sym = SYM_ONE;
        one_half_phase_next = 1'b1;
      end else begin
        one_half_phase_next = 1'b0;
      end
    end else if (zero_hit) begin
      one_half_phase_next = 1'b0;
      if (zero_half_phase == 2'd0) begin
        sym = SYM_ZERO;
        zero_half_phase_next = 2'd1;
      end else if (zero_half_phase < ZERO_LAST_PHASE) begin
        zero_half_phase_next = zero_half_phase + 2'd1;
      end else begin
        zero_half_phase_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      one_half_phase <= 1'b0;
      zero_half_phase <= 2'd0;
    end else if (take) begin
      one_half_phase <= one_half_phase_next;
      zero_half_phase <= zero_half_phase_next;
    end
  end

endmodule

>>> sv/ftu_back.sv
// Back end: UART 8-bit frame assembly from decoded symbols.
module ftu_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic [ftu_pkg::SymW-1:0] sym,
  output ftu_pkg::result_t         result
);
  import ftu_pkg::*;

  logic frame_active;
  logic frame_active_next;
  logic [CountW-1:0] frame_bit_count;
  logic [CountW-1:0] frame_bit_count_next;
  logic [CharW-1:0] char_shift;
  logic [CharW-1:0] char_shift_next;
  logic [2:0] bit_idx;

  assign bit_idx = 3'(frame_bit_count - 4'd1);

  always_comb begin
    frame_active_next = frame_active;
    frame_bit_count_next = frame_bit_count;
    char_shift_next = char_shift;
    result.bit_symbol = sym;
    result.char_done = 1'b0;
    result.rx_char = '0;
    if (sym == SYM_ZERO && !frame_active) begin
      frame_active_next = 1'b1;
      frame_bit_count_next = 4'd1;
    end else if (sym != SYM_NONE && frame_active) begin
      if (frame_bit_count >= 4'd1 && frame_bit_count <= FRAME_PARITY_POS) begin
        // data bits land LSB first; the parity slot is just counted
        if (frame_bit_count <= FRAME_DATA_BITS) begin
          char_shift_next[bit_idx] = char_shift[bit_idx] | sym[0];
        end
        frame_bit_count_next = frame_bit_count + 4'd1;
      end else if (frame_bit_count == FRAME_STOP_POS && sym == SYM_ONE) begin
        result.char_done = 1'b1;
        result.rx_char = char_shift;
        frame_bit_count_next = '0;
        frame_active_next = 1'b0;
        char_shift_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active <= 1'b0;
      frame_bit_count <= '0;
      char_shift <= '0;
    end else if (take) begin
      frame_active <= frame_active_next;
      frame_bit_count <= frame_bit_count_next;
      char_shift <= char_shift_next;
    end
  end

endmodule

>>> tb/ftu_decode_checker.sv
`timescale 1ns / 1ps
// Checker for the FSK tone UART receiver: decodes each accepted measurement and compares words.
module ftu_decode_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        full,
  input  logic [ftu_pkg::ValW-1:0]    half_period_ticks,
  input  logic                        empty,
  input  logic                        pop,
  input  logic [ftu_pkg::SymW-1:0]    bit_symbol,
  input  logic                        char_done,
  input  logic [ftu_pkg::CharW-1:0]   rx_char,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [ftu_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ftu_pkg::ValW-1:0]    cfg_data,
  output int                          bad_words,
  output int                          words_in_flight
);
  import ftu_pkg::*;

  localparam int ShownFaults = 10;

  thresh_t          win;
  logic             one_phase;
  logic [1:0]       zero_phase;
  logic             in_frame;
  logic [CountW-1:0] bit_pos;
  logic [CharW-1:0] shift_reg;
  result_t          decoded_q[$];
  int               faults;
  int               words_seen;

  // Tone classifier followed by the 8-bit framer; updates the mirrored state.
  function automatic result_t decode_half_period(input logic [ValW-1:0] t);
    result_t r;
    logic [SymW-1:0] sym;
    sym = SYM_NONE;
    r = '0;
    if (win.one_min < t && t < win.one_max) begin
      zero_phase = 2'd0;
      if (!one_phase) begin
        sym = SYM_ONE;
        one_phase = 1'b1;
      end else begin
        one_phase = 1'b0;
      end
    end else if (win.zero_min < t && t < win.zero_max) begin
      one_phase = 1'b0;
      if (zero_phase == 2'd0) begin
        sym = SYM_ZERO;
        zero_phase = 2'd1;
      end else if (zero_phase < ZERO_LAST_PHASE) begin
        zero_phase = zero_phase + 2'd1;
      end else begin
        zero_phase = 2'd0;
      end
    end

    if (sym == SYM_ZERO && !in_frame) begin
      in_frame = 1'b1;
      bit_pos = 4'd1;
    end else if (sym != SYM_NONE && in_frame) begin
      if (bit_pos >= 4'd1 && bit_pos <= FRAME_PARITY_POS) begin
        if (bit_pos <= FRAME_DATA_BITS)
          shift_reg = shift_reg | (CharW'(sym) << (bit_pos - 4'd1));
        bit_pos = bit_pos + 4'd1;
      end else if (bit_pos == FRAME_STOP_POS && sym == SYM_ONE) begin
        r.char_done = 1'b1;
        r.rx_char = shift_reg;
        bit_pos = '0;
        in_frame = 1'b0;
        shift_reg = '0;
      end
    end
    r.bit_symbol = sym;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      win = '0;
      one_phase = 1'b0;
      zero_phase = '0;
      in_frame = 1'b0;
      bit_pos = '0;
      shift_reg = '0;
      decoded_q.delete();
      faults = 0;
      words_seen = 0;
      bad_words <= 0;
      words_in_flight <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ONE_MIN:  win.one_min = cfg_data;
          REG_ONE_MAX:  win.one_max = cfg_data;
          REG_ZERO_MIN: win.zero_min = cfg_data;
          REG_ZERO_MAX: win.zero_max = cfg_data;
          default: ;
        endcase
      end

      // check the outgoing word before queueing this edge's prediction
      if (pop && !empty) begin
        got.bit_symbol = bit_symbol;
        got.char_done = char_done;
        got.rx_char = rx_char;
        if (decoded_q.size() == 0) begin
          faults++;
          if (faults <= ShownFaults)
            $display("unexpected decoded word %0d: sym=%0d done=%0d char=%02h",
                     words_seen, got.bit_symbol, got.char_done, got.rx_char);
        end else begin
          want = decoded_q.pop_front();
          if (got.bit_symbol !== want.bit_symbol || got.char_done !== want.char_done ||
              got.rx_char !== want.rx_char) begin
            faults++;
            if (faults <= ShownFaults)
              $display("decoded word %0d: expected sym=%0d done=%0d char=%02h, got sym=%0d done=%0d char=%02h",
                       words_seen, want.bit_symbol, want.char_done, want.rx_char,
                       got.bit_symbol, got.char_done, got.rx_char);
          end
        end
        words_seen++;
      end

      if (push && !full)
        decoded_q.push_back(decode_half_period(half_period_ticks));

      bad_words <= faults;
      words_in_flight <= decoded_q.size();
    end
  end

endmodule

>>> tb/tb_fsk_tone_uart_receiver.sv
`timescale 1ns / 1ps
// Top-level testbench for the FSK tone UART receiver: stimulus, watchdog and verdict.
module tb_fsk_tone_uart_receiver;
  import ftu_pkg::*;

  localparam int StallLimit = 2000;
  localparam logic [CfgIdxW-1:0] REG_SPARE = 8'hFC;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [ValW-1:0]     half_period_ticks = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [SymW-1:0]     bit_symbol;
  logic                char_done;
  logic [CharW-1:0]    rx_char;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [ValW-1:0]     cfg_data = '0;

  int                  bad_words;
  int                  words_in_flight;
  int                  items_sent = 0;
  int                  idle_cycles = 0;
  bit                  calm = 1'b0;
  logic [ValW-1:0]     one_lo = '0, one_hi = '0, zero_lo = '0, zero_hi = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fsk_tone_uart_receiver u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .half_period_ticks(half_period_ticks),
    .empty(empty), .pop(pop),
    .bit_symbol(bit_symbol), .char_done(char_done), .rx_char(rx_char),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ftu_decode_checker u_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .half_period_ticks(half_period_ticks),
    .empty(empty), .pop(pop),
    .bit_symbol(bit_symbol), .char_done(char_done), .rx_char(rx_char),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .bad_words(bad_words), .words_in_flight(words_in_flight)
  );

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == StallLimit) begin
        $display("** fsk_tone_uart_receiver: FAILED **");
        $finish;
      end
    end
  end

  initial begin : result_side
    forever begin
      @(posedge clk);
      pop <= calm || ($urandom_range(99) >= 26);
    end
  end

  function automatic bit in_one(input logic [ValW-1:0] t);
    return one_lo < t && t < one_hi;
  endfunction

  function automatic bit in_zero(input logic [ValW-1:0] t);
    return zero_lo < t && t < zero_hi;
  endfunction

  function automatic logic [ValW-1:0] one_tick();
    if (int'(one_hi) - int'(one_lo) < 2)
      return ValW'($urandom);
    return ValW'($urandom_range(int'(one_hi) - 1, int'(one_lo) + 1));
  endfunction

  // a zero half-period that the one window does not shadow, where one exists
  function automatic logic [ValW-1:0] zero_tick();
    logic [ValW-1:0] t;
    if (int'(zero_hi) - int'(zero_lo) < 2)
      return ValW'($urandom);
    for (int i = 0; i < 8; i++) begin
      t = ValW'($urandom_range(int'(zero_hi) - 1, int'(zero_lo) + 1));
      if (!in_one(t))
        return t;
    end
    return t;
  endfunction

  function automatic logic [ValW-1:0] stray_tick();
    logic [ValW-1:0] t;
    for (int i = 0; i < 16; i++) begin
      t = ValW'($urandom);
      if (!in_one(t) && !in_zero(t))
        return t;
    end
    return t;
  endfunction

  function automatic logic [ValW-1:0] noise_tick();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40)
      return ValW'($urandom);
    if (roll < 70)
      return stray_tick();
    case ($urandom_range(3))
      0: return one_lo;
      1: return one_hi;
      2: return zero_lo;
      default: return zero_hi;
    endcase
  endfunction

  task automatic send_word(input logic [ValW-1:0] t);
    while (!calm && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    half_period_ticks <= t;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  // one bit on the line: two low-tone or four high-tone half-periods, odd glitch between
  task automatic send_bit(input logic b);
    repeat (b ? 2 : 4) begin
      if ($urandom_range(99) < 3)
        send_word(stray_tick());
      send_word(b ? one_tick() : zero_tick());
    end
  endtask

  task automatic send_frame(input logic [CharW-1:0] ch, input logic par, input int zeros_at_stop);
    send_bit(1'b0);
    for (int i = 0; i < CharW; i++)
      send_bit(ch[i]);
    send_bit(par);
    repeat (zeros_at_stop) send_bit(1'b0);
    send_bit(1'b1);
  endtask

  task automatic send_chunk();
    int roll;
    int k;
    logic [CharW-1:0] ch;
    roll = $urandom_range(99);
    ch = CharW'($urandom);
    if (roll < 70) begin
      repeat ($urandom_range(2)) send_bit(1'b1);
      send_frame(ch, 1'($urandom), 0);
    end else if (roll < 84) begin
      case ($urandom_range(2))
        0: begin
          // frame cut short; the framer carries on into whatever follows
          send_bit(1'b0);
          k = $urandom_range(CharW);
          for (int i = 0; i < k; i++)
            send_bit(ch[i]);
        end
        1: send_frame(ch, 1'($urandom), $urandom_range(1, 2));
        default: begin
          if ($urandom_range(1))
            repeat ($urandom_range(1, 3)) send_word(one_tick());
          else
            repeat ($urandom_range(1, 3)) send_word(zero_tick());
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 4)) send_word(noise_tick());
    end
  endtask

  task automatic run_items(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target)
      send_chunk();
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ValW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic change_windows(input logic [ValW-1:0] om, input logic [ValW-1:0] ox,
                                input logic [ValW-1:0] zm, input logic [ValW-1:0] zx,
                                input bit spare);
    wait_drained();
    repeat (4) @(posedge clk);
    if (spare)
      write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_ONE_MIN, om);
    write_reg(REG_ONE_MAX, ox);
    write_reg(REG_ZERO_MIN, zm);
    write_reg(REG_ZERO_MAX, zx);
    cfg_valid <= 1'b0;
    one_lo = om;
    one_hi = ox;
    zero_lo = zm;
    zero_hi = zx;
  endtask

  initial begin : stimulus
    int a;
    int aw;
    int b;
    int bw;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // thresholds still at reset: nothing can match
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h0001);

    // both windows span everything: low tone wins, bounds themselves excluded
    change_windows(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h0001);
    send_word(16'hFFFE);

    // nominal windows with a write to an unused index first
    change_windows(16'd100, 16'd200, 16'd40, 16'd80, 1'b1);
    send_word(16'd100);
    send_word(16'd200);
    send_word(16'd40);
    send_word(16'd80);
    send_word(16'd101);
    send_word(16'd199);
    send_word(16'd41);
    send_word(16'd79);
    send_word(16'd41);
    send_word(16'd79);
    send_word(16'h0000);
    send_word(16'hFFFF);

    calm = 1'b1;
    run_items(200);
    calm = 1'b0;
    run_items(60);
    wait_drained();
    run_items(260);

    // disjoint windows in either order
    repeat (2) begin
      a = $urandom_range(20000);
      aw = $urandom_range(2, 4000);
      b = a + aw + $urandom_range(2000);
      bw = $urandom_range(2, 4000);
      if ($urandom_range(1))
        change_windows(ValW'(a), ValW'(a + aw), ValW'(b), ValW'(b + bw), 1'b0);
      else
        change_windows(ValW'(b), ValW'(b + bw), ValW'(a), ValW'(a + aw), 1'b0);
      run_items(200);
    end

    // low-tone window nested inside the high-tone one
    a = $urandom_range(30000);
    change_windows(ValW'(a + 1000), ValW'(a + 1500), ValW'(a), ValW'(a + 3000), 1'b0);
    run_items(300);

    // low-tone window inverted: only zeros, so the framer stalls at the stop position
    change_windows(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    run_items(100);

    // both windows one tick wide, hence empty
    change_windows(16'd1000, 16'd1001, 16'd1001, 16'd1002, 1'b0);
    run_items(40);

    change_windows(16'd64000, 16'hFFFF, 16'h0000, 16'd30, 1'b0);
    run_items(150);

    wait_drained();
    repeat (8) @(posedge clk);
    if (bad_words == 0 && words_in_flight == 0)
      $display("** fsk_tone_uart_receiver: PASSED **");
    else
      $display("** fsk_tone_uart_receiver: FAILED **");
    $finish;
  end

endmodule
